// ===== hdl/rgb_chromaticity_normalizer_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef RGB_CHROMATICITY_NORMALIZER_MACROS_SVH
`define RGB_CHROMATICITY_NORMALIZER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RCN_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RCN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rcn_pkg.sv =====
package rcn_pkg;

  localparam int unsigned PIXEL_W   = 24;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned SUM_W     = 10;  // 3 * 255 = 765
  localparam int unsigned CHROMA_W  = 11;  // 0..1024
  localparam int unsigned NUM_CELLS = CHROMA_W;  // one quotient bit per cell

  localparam int unsigned RED_LSB   = 16;
  localparam int unsigned GREEN_LSB = 8;
  localparam int unsigned BLUE_LSB  = 0;

  // Data handed from one divider cell to the next.
  typedef struct packed {
    logic [SUM_W-1:0]    rem_r;
    logic [SUM_W-1:0]    rem_g;
    logic [SUM_W-1:0]    divisor;
    logic [CHROMA_W-1:0] quo_r;
    logic [CHROMA_W-1:0] quo_g;
    logic                zero;
  } cell_data_t;

endpackage

// ===== hdl/rcn_if.sv =====
interface rcn_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [rcn_pkg::PIXEL_W-1:0]   pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface rcn_chroma_if;
  logic                          valid;
  logic                          ready;
  logic [rcn_pkg::CHROMA_W-1:0]  red_chroma;
  logic [rcn_pkg::CHROMA_W-1:0]  green_chroma;
  logic                          zero_sum;

  modport source (output valid, output red_chroma, output green_chroma,
                  output zero_sum, input ready);
  modport sink   (input valid, input red_chroma, input green_chroma,
                  input zero_sum, output ready);
endinterface

// ===== hdl/rcn_cell.sv =====
`include "rgb_chromaticity_normalizer_macros.svh"

// One restoring-division step for both lanes, plus its stage register.
module rcn_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  rcn_pkg::cell_data_t up_data,
  input  logic                fill_r,
  input  logic                fill_g,
  output logic                dn_valid,
  input  logic                dn_ready,
  output rcn_pkg::cell_data_t dn_data
);

  logic                   valid;
  rcn_pkg::cell_data_t    data;
  rcn_pkg::cell_data_t    data_next;
  logic [rcn_pkg::SUM_W:0] trial_r;
  logic [rcn_pkg::SUM_W:0] trial_g;
  logic [rcn_pkg::SUM_W:0] dvs;
  logic                   ge_r;
  logic                   ge_g;
  logic [rcn_pkg::SUM_W:0] diff_r;
  logic [rcn_pkg::SUM_W:0] diff_g;

  always_comb begin
    trial_r = {up_data.rem_r, fill_r};
    trial_g = {up_data.rem_g, fill_g};
    dvs     = {1'b0, up_data.divisor};
    ge_r    = (trial_r >= dvs);
    ge_g    = (trial_g >= dvs);
    diff_r  = trial_r - dvs;
    diff_g  = trial_g - dvs;

    data_next         = up_data;
    // remainder stays below the divisor, so it fits SUM_W bits
    data_next.rem_r   = ge_r ? diff_r[rcn_pkg::SUM_W-1:0] : trial_r[rcn_pkg::SUM_W-1:0];
    data_next.rem_g   = ge_g ? diff_g[rcn_pkg::SUM_W-1:0] : trial_g[rcn_pkg::SUM_W-1:0];
    data_next.quo_r   = {up_data.quo_r[rcn_pkg::CHROMA_W-2:0], ge_r};
    data_next.quo_g   = {up_data.quo_g[rcn_pkg::CHROMA_W-2:0], ge_g};
  end

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_valid && up_ready) begin
      valid <= 1'b1;
    end else if (dn_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data <= data_next;
    end
  end

  `RCN_ASSERT_NEXT(a_stall_hold, clk, rst, valid && !dn_ready, valid && $stable(data), "stalled stage lost its data")
  `RCN_ASSERT_NOW(a_rem_below_div, clk, rst, valid && !data.zero, (data.rem_r < data.divisor) && (data.rem_g < data.divisor), "remainder not below divisor")
  `RCN_ASSERT_NEXT(a_drain, clk, rst, valid && dn_ready && !up_valid, !valid, "stage kept a transferred item")

endmodule

// ===== hdl/rgb_chromaticity_normalizer.sv =====
// Channel   Dir   Payload                                   Role
// pixels    in    pixel[23:0] (R 23:16, G 15:8, B 7:0)      one pixel per transfer
// chroma    out   red_chroma[10:0] green_chroma[10:0]       one result per pixel
//                 zero_sum
//
// Throughput: one pixel per clock while chroma.ready is high; the result is
//   built in a row of 11 registered divider cells, one quotient bit per cell.
// Every cell has its own stage register; ready ripples back through the cells
//   combinationally, so a stall at the output fills empty stages first and
//   bubbles are squeezed out.
// Reset (rst, synchronous) clears only the stage valid bits.
// The last cell's register is the output register.
`include "rgb_chromaticity_normalizer_macros.svh"

module rgb_chromaticity_normalizer (
  input  logic                 clk,
  input  logic                 rst,
  rcn_pixel_if.sink            pixels,
  rcn_chroma_if.source         chroma
);

  localparam int unsigned N = rcn_pkg::NUM_CELLS;

  // link[k] feeds cell k; link[N] is the output register
  rcn_pkg::cell_data_t link       [N+1];
  logic                link_valid [N+1];
  logic                link_ready [N+1];

  logic [rcn_pkg::CHAN_W-1:0] red;
  logic [rcn_pkg::CHAN_W-1:0] green;
  logic [rcn_pkg::CHAN_W-1:0] blue;
  logic [rcn_pkg::SUM_W-1:0]  sum;

  assign red   = pixels.pixel[rcn_pkg::RED_LSB   +: rcn_pkg::CHAN_W];
  assign green = pixels.pixel[rcn_pkg::GREEN_LSB +: rcn_pkg::CHAN_W];
  assign blue  = pixels.pixel[rcn_pkg::BLUE_LSB  +: rcn_pkg::CHAN_W];

  assign sum = {{(rcn_pkg::SUM_W-rcn_pkg::CHAN_W){1'b0}}, red}
             + {{(rcn_pkg::SUM_W-rcn_pkg::CHAN_W){1'b0}}, green}
             + {{(rcn_pkg::SUM_W-rcn_pkg::CHAN_W){1'b0}}, blue};

  // Dividend is channel << 10 and channel <= sum, so the first step can
  // start from the channel itself: cell 0 shifts in the channel LSB on top
  // of channel >> 1 and decides the 1024 bit; the remaining cells shift in 0.
  assign link[0].rem_r   = {{(rcn_pkg::SUM_W-rcn_pkg::CHAN_W+1){1'b0}},
                            red[rcn_pkg::CHAN_W-1:1]};
  assign link[0].rem_g   = {{(rcn_pkg::SUM_W-rcn_pkg::CHAN_W+1){1'b0}},
                            green[rcn_pkg::CHAN_W-1:1]};
  assign link[0].divisor = sum;
  assign link[0].quo_r   = '0;
  assign link[0].quo_g   = '0;
  assign link[0].zero    = (sum == '0);

  assign link_valid[0] = pixels.valid;
  assign pixels.ready  = link_ready[0];

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_cell
      rcn_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .up_valid (link_valid[k]),
        .up_ready (link_ready[k]),
        .up_data  (link[k]),
        .fill_r   ((k == 0) ? red[0]   : 1'b0),
        .fill_g   ((k == 0) ? green[0] : 1'b0),
        .dn_valid (link_valid[k+1]),
        .dn_ready (link_ready[k+1]),
        .dn_data  (link[k+1])
      );
    end
  endgenerate

  // Black pixel: zero divisor drives every quotient bit high, so mask it.
  assign chroma.valid        = link_valid[N];
  assign link_ready[N]       = chroma.ready;
  assign chroma.zero_sum     = link[N].zero;
  assign chroma.red_chroma   = link[N].zero ? '0 : link[N].quo_r;
  assign chroma.green_chroma = link[N].zero ? '0 : link[N].quo_g;

endmodule
